FILE: design/life_generation_stream_defines.svh
// ----------------------------------------------------------------------------
// Life generation stream: assertion macros
// Shared property wrappers clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_STREAM_DEFINES_SVH
`define LIFE_GENERATION_STREAM_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define LGE_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("life_generation_stream: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define LGE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("life_generation_stream: next-cycle check failed");

`endif

FILE: design/lge_pkg.sv
// ----------------------------------------------------------------------------
// Life generation stream: package
// Sizes, register indexes, window types and the B3/S23 rule.
// ----------------------------------------------------------------------------
package lge_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int EFF_W_W    = $clog2(MAX_WIDTH + 1);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = HEIGHT_W + 1;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int COUNT_W    = 4;
    localparam int COL_BITS   = 3;
    localparam int LINE_BITS  = 2;
    localparam int WIN_CELLS  = 2;
    localparam int CMP_W      = (WIDTH_W > EFF_W_W) ? WIDTH_W : EFF_W_W;

    localparam logic [CFG_IDX_W-1:0] REG_BOARD_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_HEIGHT = CFG_IDX_W'(1);

    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(64);
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(64);

    // One window column: bit 0 upper row, bit 1 middle row, bit 2 lower row
    typedef logic [COL_BITS-1:0] column_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic kill;
    } cell_ctrl_t;

    function automatic logic [EFF_W_W-1:0] eff_width(input logic [WIDTH_W-1:0] raw);
        logic [CMP_W-1:0]   ext;
        logic [EFF_W_W-1:0] res;
        ext = CMP_W'(raw);
        if (raw == '0)
        begin
            res = EFF_W_W'(1);
        end
        else if (ext > CMP_W'(MAX_WIDTH))
        begin
            res = EFF_W_W'(MAX_WIDTH);
        end
        else
        begin
            res = EFF_W_W'(raw);
        end
        return res;
    endfunction

    function automatic logic [HEIGHT_W-1:0] eff_height(input logic [HEIGHT_W-1:0] raw);
        return (raw == '0) ? HEIGHT_W'(1) : raw;
    endfunction

    // Live cells of the 3x3 window, centre excluded
    function automatic logic [COUNT_W-1:0] count_live(input logic [8:0] view);
        logic [COUNT_W-1:0] n;
        n = '0;
        for (int b = 0; b < 9; b++)
        begin
            if (b != 4)
            begin
                n = n + COUNT_W'(view[b]);
            end
        end
        return n;
    endfunction

    function automatic logic next_state(input logic centre, input logic [COUNT_W-1:0] n);
        return (n == COUNT_W'(3)) || (centre && (n == COUNT_W'(2)));
    endfunction

endpackage

FILE: design/lge_ram.sv
// ----------------------------------------------------------------------------
// Life generation stream: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lge_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/lge_cell.sv
// ----------------------------------------------------------------------------
// Life generation stream: window cell
// Holds one three-row column of the window and passes it on each shift.
// ----------------------------------------------------------------------------
module lge_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  lge_pkg::cell_ctrl_t ctrl,
    input  lge_pkg::column_t    d_in,
    output lge_pkg::column_t    q
);

    lge_pkg::column_t col_reg;
    lge_pkg::column_t col_next;

    always_comb
    begin
        col_next = col_reg;
        if (ctrl.clear)
        begin
            col_next = '0;
        end
        else if (ctrl.shift)
        begin
            // drop the incoming column at a row start
            col_next = ctrl.kill ? lge_pkg::column_t'(0) : d_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    assign q = col_reg;

endmodule

FILE: design/life_generation_stream.sv
// Result path: a cell's result passes through the read stage and then the output register once the
//   item that lies one row plus one column behind it is transferred (padding tail included).
// Throughput: one item per cycle while results are taken; a held result stalls
//   the input once the read stage and the output register are both full.
// Reset: counters, window and handshake clear; width and height return to 64.
//   The line RAM is not cleared: the row counter masks every unwritten entry.
// ----------------------------------------------------------------------------
// Life generation stream: top level
// One B3/S23 generation over a raster-order board, one cell per transfer.
// ----------------------------------------------------------------------------
`include "life_generation_stream_defines.svh"

module life_generation_stream (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [lge_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lge_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cur_alive,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                next_alive,
    output logic [lge_pkg::COUNT_W-1:0]         live_neighbours,
    output logic                                last_cell
);

    // Board size
    logic [lge_pkg::EFF_W_W-1:0]  width_eff_reg;
    logic [lge_pkg::HEIGHT_W-1:0] height_eff_reg;

    // Raster counters
    logic [lge_pkg::COL_W-1:0]    col_reg;
    logic [lge_pkg::COL_W-1:0]    col_next;
    logic [lge_pkg::ROW_W-1:0]    row_reg;
    logic [lge_pkg::ROW_W-1:0]    row_next;

    // Read stage
    logic                         s1_valid_reg;
    logic                         s1_bot_reg;
    logic                         s1_mid_en_reg;
    logic                         s1_top_en_reg;
    logic                         s1_czero_reg;
    logic                         s1_res_reg;
    logic                         s1_last_reg;
    logic [lge_pkg::COL_W-1:0]    s1_addr_reg;
    logic                         s1_byp_reg;
    logic [lge_pkg::LINE_BITS-1:0] s1_byp_data_reg;

    // Output register
    logic                         out_valid_reg;
    logic                         next_alive_reg;
    logic [lge_pkg::COUNT_W-1:0]  live_neighbours_reg;
    logic                         last_cell_reg;

    logic                         in_fire;
    logic                         s2_fire;
    logic [lge_pkg::EFF_W_W-1:0]  col_plus_one;
    logic [lge_pkg::ROW_W-1:0]    height_plus_one;
    logic                         in_czero;
    logic                         in_last;
    logic                         in_bot;

    logic [lge_pkg::LINE_BITS-1:0] ram_rd_data;
    logic [lge_pkg::LINE_BITS-1:0] line_rd;
    logic [lge_pkg::LINE_BITS-1:0] line_wr;
    logic                         s2_mid;
    logic                         s2_top;
    lge_pkg::column_t             s2_col;
    lge_pkg::column_t             cell_q [lge_pkg::WIN_CELLS];
    logic [8:0]                   view;
    logic [lge_pkg::COUNT_W-1:0]  view_count;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign s2_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_fire;
    assign in_fire  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_eff_reg  <= lge_pkg::eff_width(lge_pkg::RESET_WIDTH);
            height_eff_reg <= lge_pkg::eff_height(lge_pkg::RESET_HEIGHT);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lge_pkg::REG_BOARD_WIDTH:
                begin
                    width_eff_reg <= lge_pkg::eff_width(cfg_data[lge_pkg::WIDTH_W-1:0]);
                end
                lge_pkg::REG_BOARD_HEIGHT:
                begin
                    height_eff_reg <= lge_pkg::eff_height(cfg_data[lge_pkg::HEIGHT_W-1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Raster position of the incoming item
    // ------------------------------------------------------------------
    assign col_plus_one    = lge_pkg::EFF_W_W'(col_reg) + lge_pkg::EFF_W_W'(1);
    assign height_plus_one = lge_pkg::ROW_W'(height_eff_reg) + lge_pkg::ROW_W'(1);
    assign in_czero        = (col_reg == '0);
    assign in_last         = in_czero && (row_reg == height_plus_one);
    // padding rows read as dead
    assign in_bot          = (row_reg < lge_pkg::ROW_W'(height_eff_reg)) && cur_alive;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr_en)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_fire)
        begin
            if (in_last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_plus_one >= width_eff_reg)
            begin
                col_next = '0;
                row_next = row_reg + lge_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_plus_one[lge_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Read stage: issue the line read, hold the item's flags
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s2_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_bot_reg      <= in_bot;
            s1_mid_en_reg   <= (row_reg >= lge_pkg::ROW_W'(1));
            s1_top_en_reg   <= (row_reg >= lge_pkg::ROW_W'(2));
            s1_czero_reg    <= in_czero;
            s1_res_reg      <= in_czero ? (row_reg >= lge_pkg::ROW_W'(2))
                                        : (row_reg >= lge_pkg::ROW_W'(1));
            s1_last_reg     <= in_last;
            s1_addr_reg     <= col_reg;
            // forward a write to the same entry landing on this edge
            s1_byp_reg      <= s2_fire && (s1_addr_reg == col_reg);
            s1_byp_data_reg <= line_wr;
        end
    end

    lge_ram #(
        .WIDTH (lge_pkg::LINE_BITS),
        .DEPTH (lge_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s2_fire),
        .wr_addr (s1_addr_reg),
        .wr_data (line_wr),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Window stage: bit 1 of a line entry is the upper row, bit 0 the middle
    // ------------------------------------------------------------------
    assign line_rd = s1_byp_reg ? s1_byp_data_reg : ram_rd_data;
    assign s2_mid  = s1_mid_en_reg && line_rd[0];
    assign s2_top  = s1_top_en_reg && line_rd[1];
    assign s2_col  = {s1_bot_reg, s2_mid, s2_top};
    assign line_wr = {s2_mid, s1_bot_reg};

    generate
        for (genvar i = 0; i < lge_pkg::WIN_CELLS; i++)
        begin : g_cell
            lge_pkg::cell_ctrl_t ctrl;
            lge_pkg::column_t    d_in;

            assign ctrl.shift = s2_fire;
            assign ctrl.clear = cfg_wr_en;
            if (i == lge_pkg::WIN_CELLS - 1)
            begin : g_head
                assign ctrl.kill = 1'b0;
                assign d_in      = s2_col;
            end
            else
            begin : g_body
                assign ctrl.kill = s1_czero_reg;
                assign d_in      = cell_q[i+1];
            end

            lge_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .d_in  (d_in),
                .q     (cell_q[i])
            );
        end
    endgenerate

    // At a row start the right column lies off the board
    assign view       = {(s1_czero_reg ? lge_pkg::column_t'(0) : s2_col), cell_q[1], cell_q[0]};
    assign view_count = lge_pkg::count_live(view);

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_fire)
        begin
            out_valid_reg <= s1_res_reg;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire && s1_res_reg)
        begin
            next_alive_reg      <= lge_pkg::next_state(view[4], view_count);
            live_neighbours_reg <= view_count;
            last_cell_reg       <= s1_last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign next_alive      = next_alive_reg;
    assign live_neighbours = live_neighbours_reg;
    assign last_cell       = last_cell_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LGE_ASSERT(a_col_in_board, 1'b1, lge_pkg::EFF_W_W'(col_reg) < width_eff_reg)
    `LGE_ASSERT(a_row_in_frame, 1'b1, row_reg <= height_plus_one)
    `LGE_ASSERT_NEXT(a_restart_after_last, in_fire && in_last, (col_reg == '0) && (row_reg == '0))
    `LGE_ASSERT(a_count_range, out_valid_reg, live_neighbours_reg <= lge_pkg::COUNT_W'(8))

endmodule
